FILE: design/iteration_count_palette_core_defines.svh
// ----------------------------------------------------------------------------
// iteration_count_palette_core_defines
// Assertion macros shared by the palette core. The enclosing module must
// provide clk and rst.
// ----------------------------------------------------------------------------
`ifndef ITERATION_COUNT_PALETTE_CORE_DEFINES_SVH
`define ITERATION_COUNT_PALETTE_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define ICP_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("icp check failed");

// next-cycle implication, disabled in reset
`define ICP_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("icp check failed");

`endif

FILE: design/icp_pkg.sv
// ----------------------------------------------------------------------------
// icp_pkg
// Widths, register and palette codes, and polynomial descriptors shared by
// the iteration-count palette core.
// ----------------------------------------------------------------------------
package icp_pkg;

  localparam int unsigned FRAC_BITS_DEF = 24;
  localparam int unsigned IT_W          = 16;
  localparam int unsigned COLOR_W       = 26;
  localparam int unsigned CH_W          = 10;
  localparam int unsigned KW            = 13;
  localparam int unsigned NSTEP         = 5;
  localparam int unsigned NSLOT         = 3;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [IT_W-1:0]   ITER_LIMIT_RST = 16'd100;
  localparam logic [MODE_W-1:0] MODE_RST       = 2'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_MODE = 2'd1;

  // palette modes
  localparam logic [MODE_W-1:0] PAL_STD  = 2'd0;
  localparam logic [MODE_W-1:0] PAL_GLOW = 2'd1;
  localparam logic [MODE_W-1:0] PAL_FIRE = 2'd2;
  localparam logic [MODE_W-1:0] PAL_RGB  = 2'd3;

  // packing slots: hi at bit 16, mid at bit 8, lo at bit 0
  localparam int unsigned SLOT_LO  = 0;
  localparam int unsigned SLOT_MID = 1;
  localparam int unsigned SLOT_HI  = 2;

  // coefficients times 255; whole-number ones doubled so every channel
  // shares the same final shift of NSTEP*FRAC_BITS+1
  localparam logic [KW-1:0] K9X2  = 13'd4590;
  localparam logic [KW-1:0] K15X2 = 13'd7650;
  localparam logic [KW-1:0] K17   = 13'd4335;

  typedef enum logic [1:0] {
    FS_ONE = 2'd0,
    FS_T   = 2'd1,
    FS_U   = 2'd2
  } fsel_t;

  typedef struct packed {
    logic [KW-1:0]           k;
    fsel_t [NSTEP-1:0]       f;
  } poly_t;

  typedef poly_t [NSLOT-1:0] pset_t;

  // k * t^a * u^b, padded with unit factors up to NSTEP
  function automatic poly_t make_poly(logic [KW-1:0] k, int unsigned a, int unsigned b);
    poly_t p;
    p.k = k;
    for (int unsigned j = 0; j < NSTEP; j++) begin
      if (j < a) begin
        p.f[j] = FS_T;
      end else if (j < a + b) begin
        p.f[j] = FS_U;
      end else begin
        p.f[j] = FS_ONE;
      end
    end
    return p;
  endfunction

  function automatic pset_t palette(logic [MODE_W-1:0] mode);
    pset_t s;
    case (mode)
      PAL_GLOW: begin
        s[SLOT_HI]  = make_poly(K9X2, 1, 1);
        s[SLOT_MID] = make_poly(K17, 1, 3);
        s[SLOT_LO]  = make_poly(K15X2, 2, 2);
      end
      PAL_FIRE: begin
        s[SLOT_HI]  = make_poly(K9X2, 1, 1);
        s[SLOT_MID] = make_poly(K15X2, 2, 2);
        s[SLOT_LO]  = make_poly(K17, 2, 3);
      end
      PAL_RGB: begin
        s[SLOT_HI]  = make_poly(K9X2, 3, 1);
        s[SLOT_MID] = make_poly(K15X2, 2, 2);
        s[SLOT_LO]  = make_poly(K17, 1, 3);
      end
      default: begin
        s[SLOT_HI]  = make_poly(K15X2, 2, 2);
        s[SLOT_MID] = make_poly(K17, 1, 3);
        s[SLOT_LO]  = make_poly(K9X2, 3, 1);
      end
    endcase
    return s;
  endfunction

endpackage

FILE: design/icp_div.sv
// ----------------------------------------------------------------------------
// icp_div
// Pipelined restoring divider: q = (it << FRAC_BITS) / m for it <= m,
// one quotient bit per stage, FRAC_BITS+1 stages.
// ----------------------------------------------------------------------------
module icp_div #(
  parameter int unsigned FRAC_BITS = icp_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_vld,
  input  logic [icp_pkg::IT_W-1:0] in_it,
  input  logic [icp_pkg::IT_W-1:0] m,
  output logic                     out_vld,
  output logic [FRAC_BITS:0]       out_q
);
  import icp_pkg::*;

  localparam int unsigned NST = FRAC_BITS + 1;

  logic                vld [NST];
  logic [IT_W-1:0]     rem [NST];
  logic [FRAC_BITS:0]  quo [NST];

  for (genvar k = 0; k < NST; k++) begin : g_bit
    logic               v_in;
    logic [IT_W-1:0]    r_in;
    logic [FRAC_BITS:0] q_in;
    logic [IT_W:0]      d;
    logic               ge;

    if (k == 0) begin : g_first
      // integer bit: set only when it equals m
      assign v_in = in_vld;
      assign r_in = in_it;
      assign q_in = '0;
      assign d    = {1'b0, r_in};
    end else begin : g_rest
      assign v_in = vld[k-1];
      assign r_in = rem[k-1];
      assign q_in = quo[k-1];
      assign d    = {r_in, 1'b0};
    end

    assign ge = (d >= {1'b0, m});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= v_in;
      end
      // remainder stays below m, so it fits IT_W bits
      rem[k] <= ge ? IT_W'(d - {1'b0, m}) : d[IT_W-1:0];
      quo[k] <= {q_in[FRAC_BITS-1:0], ge};
    end
  end

  assign out_vld = vld[NST-1];
  assign out_q   = quo[NST-1];

endmodule

FILE: design/icp_chan.sv
// ----------------------------------------------------------------------------
// icp_chan
// One color channel: floor(k * t^a * u^b / 2^(F*(a+b)+s)), exact. The
// product is built over NSTEP steps, each a limb-wise multiply stage and a
// carry-propagate add stage; unit factors shift by FRAC_BITS.
// ----------------------------------------------------------------------------
module icp_chan #(
  parameter int unsigned FRAC_BITS = icp_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic [FRAC_BITS-1:0]     t,
  input  logic [FRAC_BITS-1:0]     u,
  input  icp_pkg::poly_t           poly,
  output logic [icp_pkg::CH_W-1:0] ch
);
  import icp_pkg::*;

  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned W  = (NSTEP + 1) * F;
  localparam int unsigned PW = 2 * F;

  logic [NSTEP-1:0][PW-1:0] ppa [NSTEP];
  logic [F-1:0]             ta  [NSTEP-1];
  logic [F-1:0]             ua  [NSTEP-1];
  logic [W-1:0]             xb  [NSTEP];
  logic [F-1:0]             tb  [NSTEP-1];
  logic [F-1:0]             ub  [NSTEP-1];

  for (genvar j = 0; j < NSTEP; j++) begin : g_step
    logic [W-1:0]             x_in;
    logic [F-1:0]             t_in;
    logic [F-1:0]             u_in;
    logic [F-1:0]             f;
    logic [NSTEP-1:0][PW-1:0] pp;
    logic [W-1:0]             ev;
    logic [W-1:0]             od;

    if (j == 0) begin : g_first
      assign x_in = {{(W-KW){1'b0}}, poly.k};
      assign t_in = t;
      assign u_in = u;
    end else begin : g_next
      assign x_in = xb[j-1];
      assign t_in = tb[j-1];
      assign u_in = ub[j-1];
    end

    always_comb begin
      case (poly.f[j])
        FS_T:    f = t_in;
        FS_U:    f = u_in;
        default: f = '0;
      endcase
    end

    // step j only carries j+1 nonzero limbs
    always_comb begin
      for (int i = 0; i < NSTEP; i++) begin
        if (i > j) begin
          pp[i] = '0;
        end else if (poly.f[j] == FS_ONE) begin
          pp[i] = {x_in[i*F +: F], {F{1'b0}}};
        end else begin
          pp[i] = {{F{1'b0}}, x_in[i*F +: F]} * {{F{1'b0}}, f};
        end
      end
    end

    // even and odd limb products do not overlap among themselves
    always_comb begin
      ev = '0;
      od = '0;
      for (int i = 0; i < NSTEP; i++) begin
        if (i[0]) begin
          od[i*F +: PW] = ppa[j][i];
        end else begin
          ev[i*F +: PW] = ppa[j][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      ppa[j] <= pp;
      xb[j]  <= ev + od;
    end

    if (j < NSTEP - 1) begin : g_carry
      always_ff @(posedge clk) begin
        ta[j] <= t_in;
        ua[j] <= u_in;
        tb[j] <= ta[j];
        ub[j] <= ua[j];
      end
    end
  end

  assign ch = xb[NSTEP-1][NSTEP*F+1 +: CH_W];

endmodule

FILE: design/iteration_count_palette_core.sv
// ----------------------------------------------------------------------------
// iteration_count_palette_core
// Throughput: one pixel per cycle; busy is low outside reset, done is a
// strobe that the receiver cannot hold off. The divider (one quotient bit
// per stage) and the 5-step channel multipliers set the depth. Reset clears
// pipeline valids and loads iter_limit = 100, palette_mode = 0.
// ----------------------------------------------------------------------------
`include "iteration_count_palette_core_defines.svh"

module iteration_count_palette_core #(
  parameter int unsigned FRAC_BITS = icp_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [icp_pkg::IT_W-1:0]       iter,
  output logic                           done,
  output logic [icp_pkg::COLOR_W-1:0]    color,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [icp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [icp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import icp_pkg::*;

  localparam int unsigned CH_LAT = 2 * NSTEP;
  localparam int unsigned LAT    = FRAC_BITS + 14;

  typedef struct packed {
    logic vld;
    logic zero;
  } tag_t;

  logic [IT_W-1:0]             iter_limit;
  logic [MODE_W-1:0]           palette_mode;
  logic                        acc;
  logic                        mode_wr;
  logic                        v0;
  logic [IT_W-1:0]             it0;
  logic                        dv;
  logic [FRAC_BITS:0]          q;
  logic                        tv;
  logic                        tz;
  logic [FRAC_BITS-1:0]        t_r;
  logic [FRAC_BITS-1:0]        u_r;
  tag_t                        tag [CH_LAT];
  pset_t                       pset;
  logic [NSLOT-1:0][CH_W-1:0]  ch_val;
  logic [COLOR_W-1:0]          color_next;

  // fully pipelined: only held off while in reset
  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;
  assign mode_wr   = cfg_valid && cfg_ready && (cfg_index == REG_PALETTE_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit   <= ITER_LIMIT_RST;
      palette_mode <= MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ITER_LIMIT:   iter_limit   <= cfg_data[IT_W-1:0];
        REG_PALETTE_MODE: palette_mode <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate the count to the limit
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= acc;
    end
    it0 <= (iter > iter_limit) ? iter_limit : iter;
  end

  icp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (v0),
    .in_it   (it0),
    .m       (iter_limit),
    .out_vld (dv),
    .out_q   (q)
  );

  // t at either end of the range gives black
  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= 1'b0;
    end else begin
      tv <= dv;
    end
    tz  <= (q == '0) || q[FRAC_BITS] || (iter_limit == '0);
    t_r <= q[FRAC_BITS-1:0];
    u_r <= {FRAC_BITS{1'b0}} - q[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CH_LAT; i++) begin
        tag[i] <= '0;
      end
    end else begin
      tag[0] <= '{vld: tv, zero: tz};
      for (int i = 1; i < CH_LAT; i++) begin
        tag[i] <= tag[i-1];
      end
    end
  end

  assign pset = palette(palette_mode);

  for (genvar s = 0; s < NSLOT; s++) begin : g_slot
    icp_chan #(.FRAC_BITS(FRAC_BITS)) u_chan (
      .clk  (clk),
      .t    (t_r),
      .u    (u_r),
      .poly (pset[s]),
      .ch   (ch_val[s])
    );
  end

  // channels overlap when above 255, as intended
  assign color_next = (COLOR_W'(ch_val[SLOT_HI]) << 16)
                    | (COLOR_W'(ch_val[SLOT_MID]) << 8)
                    | COLOR_W'(ch_val[SLOT_LO]);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag[CH_LAT-1].vld;
    end
    color <= tag[CH_LAT-1].zero ? '0 : color_next;
  end

  `ICP_ASSERT_IMP(a_done_latency, done, $past(start && !busy, LAT))
  `ICP_ASSERT_NXT(a_mode_write, mode_wr, palette_mode == $past(cfg_data[MODE_W-1:0]))
  `ICP_ASSERT_IMP(a_reset_quiet, $past(rst), !done && !tv)

endmodule
